FILE: src/intercept_match_table_assert.svh
// Assertion macros for the intercept match table checker.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef INTERCEPT_MATCH_TABLE_ASSERT_SVH
`define INTERCEPT_MATCH_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IMT_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IMT_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/imt_pkg.sv
// Shared types and constants for the intercept match table.
// Used by imt_cell, intercept_match_table and imt_checker; depends on nothing.
`default_nettype none

package imt_pkg;

	localparam int TABLE_SLOTS_DEF = 32;
	localparam int SLOT_MAX        = 256;
	// The slot and count fields that travel along the row are sized for the largest table.
	localparam int SLOT_W          = $clog2(SLOT_MAX);
	localparam int CNT_W           = $clog2(SLOT_MAX + 1);

	typedef enum logic [2:0] {
		CMD_INSERT   = 3'd0,
		CMD_REMOVE   = 3'd1,
		CMD_FIND_BP  = 3'd2,
		CMD_FIND_CPU = 3'd3,
		CMD_FIND_DSC = 3'd4,
		CMD_COUNT    = 3'd5,
		CMD_NTH      = 3'd6,
		CMD_CLEAR    = 3'd7
	} cmd_t;

	localparam logic [2:0] KIND_BREAKPOINT = 3'd2;
	localparam logic [2:0] KIND_CPUID      = 3'd3;
	localparam logic [2:0] KIND_DESCRIPTOR = 3'd4;

	typedef struct packed {
		logic [2:0]  command;
		logic [2:0]  entry_kind;
		logic [63:0] match_key;
		logic        any_leaf;
		logic [4:0]  slot_index;
	} req_t;

	typedef struct packed {
		logic       status;
		logic [4:0] slot_found;
		logic [5:0] active_count;
	} rsp_t;

	// A request word and the partial answer that builds up as it passes the cells.
	typedef struct packed {
		req_t              word;
		logic              done;
		logic              hit_wild;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  count;
	} query_t;

endpackage

`default_nettype wire

FILE: src/imt_cell.sv
// One slot of the intercept match table: the entry state and one stage of the query row.
// Depends on imt_pkg.
`default_nettype none

module imt_cell #(
	parameter int SLOT_ID = 0
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            advance,
	input  wire logic            in_valid,
	input  wire imt_pkg::query_t in_qry,
	output logic                 out_valid,
	output imt_pkg::query_t      out_qry
);

	localparam logic [imt_pkg::SLOT_W-1:0] MY_SLOT = imt_pkg::SLOT_W'(SLOT_ID);

	logic              active_q;
	logic [2:0]        kind_q;
	logic [63:0]       key_q;
	logic              wild_q;
	logic              set_active;
	logic              clr_active;
	imt_pkg::query_t   nxt;
	logic [imt_pkg::SLOT_W-1:0] idx_slot;
	logic [imt_pkg::CNT_W-1:0]  idx_ord;

	assign idx_slot = imt_pkg::SLOT_W'(in_qry.word.slot_index);
	assign idx_ord  = imt_pkg::CNT_W'(in_qry.word.slot_index);

	always_comb begin
		nxt        = in_qry;
		set_active = 1'b0;
		clr_active = 1'b0;
		if (in_valid) begin
			unique case (imt_pkg::cmd_t'(in_qry.word.command))
				imt_pkg::CMD_INSERT: begin
					// Slots are visited in order, so the first inactive one is the lowest.
					if (!in_qry.done && !active_q) begin
						set_active = 1'b1;
						nxt.done   = 1'b1;
						nxt.slot   = MY_SLOT;
					end
				end
				imt_pkg::CMD_REMOVE: begin
					if (active_q && idx_slot == MY_SLOT) begin
						clr_active = 1'b1;
						nxt.done   = 1'b1;
						nxt.slot   = MY_SLOT;
					end
				end
				imt_pkg::CMD_FIND_BP: begin
					if (!in_qry.done && active_q && kind_q == imt_pkg::KIND_BREAKPOINT
							&& key_q == in_qry.word.match_key) begin
						nxt.done = 1'b1;
						nxt.slot = MY_SLOT;
					end
				end
				imt_pkg::CMD_FIND_DSC: begin
					if (!in_qry.done && active_q && kind_q == imt_pkg::KIND_DESCRIPTOR
							&& key_q == in_qry.word.match_key) begin
						nxt.done = 1'b1;
						nxt.slot = MY_SLOT;
					end
				end
				imt_pkg::CMD_FIND_CPU: begin
					// A wildcard entry keeps overwriting the slot until an exact leaf is found,
					// so the last wildcard wins when no exact entry exists.
					if (!in_qry.done && active_q && kind_q == imt_pkg::KIND_CPUID) begin
						if (wild_q) begin
							nxt.hit_wild = 1'b1;
							nxt.slot     = MY_SLOT;
						end else if (key_q[31:0] == in_qry.word.match_key[31:0]) begin
							nxt.done = 1'b1;
							nxt.slot = MY_SLOT;
						end
					end
				end
				imt_pkg::CMD_COUNT: begin
					if (active_q) begin
						nxt.count = imt_pkg::CNT_W'(in_qry.count + 1'b1);
					end
				end
				imt_pkg::CMD_NTH: begin
					if (!in_qry.done && active_q) begin
						if (in_qry.count == idx_ord) begin
							nxt.done = 1'b1;
							nxt.slot = MY_SLOT;
						end else begin
							nxt.count = imt_pkg::CNT_W'(in_qry.count + 1'b1);
						end
					end
				end
				imt_pkg::CMD_CLEAR: begin
					clr_active = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= in_valid;
			if (set_active) begin
				active_q <= 1'b1;
			end else if (clr_active) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_qry <= nxt;
			if (set_active) begin
				kind_q <= in_qry.word.entry_kind;
				key_q  <= in_qry.word.match_key;
				wild_q <= (in_qry.word.entry_kind == imt_pkg::KIND_CPUID)
					&& in_qry.word.any_leaf;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/intercept_match_table.sv
// Intercept match table: a row of slot cells that each request word walks through.
// Depends on imt_pkg and imt_cell.
//
//   channel | direction | payload       | handshake
//   req     | in        | imt_pkg::req_t | req_valid, req_stall
//   rsp     | out       | imt_pkg::rsp_t | rsp_valid, rsp_stall
//
// An accepted word enters the first cell and moves one cell per cycle unless the row holds;
// the response register follows the last cell. One word is accepted per cycle unless held.
// Each cell updates its own entry as the word passes, so words see each other in order.
// When the response register is full and stalled, the whole row holds and req_stall rises.
// Reset clears the active bits and the stage valids at once; no clearing pass is needed.
`default_nettype none

module intercept_match_table #(
	parameter int TABLE_SLOTS = imt_pkg::TABLE_SLOTS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire imt_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output imt_pkg::rsp_t      rsp
);

	logic            advance;
	logic            stage_valid [TABLE_SLOTS+1];
	imt_pkg::query_t stage_qry   [TABLE_SLOTS+1];
	imt_pkg::query_t last_qry;
	imt_pkg::rsp_t   fin;
	logic            found;
	logic            rsp_valid_q;
	imt_pkg::rsp_t   rsp_q;

	assign advance   = !rsp_valid_q || !rsp_stall;
	assign req_stall = !advance;

	assign stage_qry[0]   = '{word: req, default: '0};
	assign stage_valid[0] = req_valid;

	for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
		imt_cell #(
			.SLOT_ID(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.in_valid (stage_valid[i]),
			.in_qry   (stage_qry[i]),
			.out_valid(stage_valid[i+1]),
			.out_qry  (stage_qry[i+1])
		);
	end

	assign last_qry = stage_qry[TABLE_SLOTS];
	assign found    = last_qry.done || last_qry.hit_wild;

	always_comb begin
		fin = '0;
		if (last_qry.word.command == imt_pkg::CMD_COUNT) begin
			fin.active_count = last_qry.count[5:0];
		end else if (last_qry.word.command != imt_pkg::CMD_CLEAR) begin
			fin.status = !found;
			if (found) begin
				fin.slot_found = last_qry.slot[4:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= stage_valid[TABLE_SLOTS];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= fin;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

FILE: src/imt_checker.sv
// Port-level checks for the intercept match table, bound to the top level.
// Depends on imt_pkg and intercept_match_table_assert.svh.
`default_nettype none

`include "intercept_match_table_assert.svh"

module imt_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire imt_pkg::req_t req,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire imt_pkg::rsp_t rsp
);

	logic slot_zero;
	logic count_zero;

	assign slot_zero  = (rsp.slot_found == 5'd0);
	assign count_zero = (rsp.active_count == 6'd0);

	// A request word that is held back must stay in place.
	`IMT_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req), "req moved")

	// A response that is held back must stay in place.
	`IMT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp moved")

	// The row moves whenever the response register can take a word.
	`IMT_ASSERT_SAME(a_stall_follows, 1'b1, req_stall == (rsp_valid && rsp_stall), "bad stall")

	// A failed operation reports neither a slot nor a count.
	`IMT_ASSERT_SAME(a_fail_clean, rsp_valid && rsp.status, slot_zero && count_zero, "fail has data")

	// A nonzero count comes only with success and slot zero.
	`IMT_ASSERT_SAME(a_count_clean, rsp_valid && !count_zero, !rsp.status && slot_zero, "bad count")

endmodule

bind intercept_match_table imt_checker u_imt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for intercept_match_table: directed words, then random words
// checked against a slot-table predictor kept in step with every accepted request word.
// Depends on imt_pkg and the intercept_match_table RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import imt_pkg::*;

	localparam int SLOTS = TABLE_SLOTS_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_WORDS = 232;

	localparam logic [2:0] KIND_REGISTER = 3'd0;
	localparam logic [2:0] KIND_MEM      = 3'd1;
	localparam logic [2:0] KIND_UNLISTED = 3'd7;

	localparam logic [63:0] KEY_ONES = '1;

	typedef struct {
		req_t word;
		bit   typed;
		rsp_t answer;
	} drill_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Predictor copy of the slot table.
	bit          slot_live [SLOTS];
	logic [2:0]  slot_kind [SLOTS];
	logic [63:0] slot_key  [SLOTS];
	bit          slot_wild [SLOTS];
	int          mark = 0;

	rsp_t awaited_answers[$];
	int   mismatches = 0;
	int   quiet_cycles = 0;
	int   send_idle_pct = 0;
	int   rsp_stall_pct = 0;

	drill_row_t drill[25];

	intercept_match_table DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	function automatic int live_slots();
		int i;
		int n;
		n = 0;
		for (i = 0; i < mark; i++)
			if (slot_live[i])
				n++;
		return n;
	endfunction

	// Applies one accepted word to the predicted table and returns its response.
	function automatic rsp_t table_apply(req_t w);
		rsp_t a;
		int hit;
		int wild;
		int n;
		int i;
		logic [2:0] want_kind;
		a = '0;
		hit = -1;
		wild = -1;
		n = 0;
		case (cmd_t'(w.command))
			CMD_INSERT: begin
				for (i = 0; i < mark; i++)
					if (hit < 0 && !slot_live[i])
						hit = i;
				if (hit < 0 && mark < SLOTS) begin
					hit = mark;
					mark++;
				end
				if (hit >= 0) begin
					slot_live[hit] = 1'b1;
					slot_kind[hit] = w.entry_kind;
					slot_key[hit] = w.match_key;
					slot_wild[hit] = (w.entry_kind == KIND_CPUID) && w.any_leaf;
				end
			end
			CMD_REMOVE: begin
				if (slot_live[w.slot_index]) begin
					slot_live[w.slot_index] = 1'b0;
					hit = w.slot_index;
				end
			end
			CMD_FIND_BP, CMD_FIND_DSC: begin
				want_kind = (w.command == CMD_FIND_BP) ? KIND_BREAKPOINT : KIND_DESCRIPTOR;
				for (i = 0; i < mark; i++)
					if (hit < 0 && slot_live[i] && slot_kind[i] == want_kind
							&& slot_key[i] == w.match_key)
						hit = i;
			end
			CMD_FIND_CPU: begin
				// An exact leaf wins; otherwise the highest live wildcard entry answers.
				for (i = 0; i < mark; i++) begin
					if (slot_live[i] && slot_kind[i] == KIND_CPUID) begin
						if (slot_wild[i])
							wild = i;
						else if (hit < 0 && slot_key[i][31:0] == w.match_key[31:0])
							hit = i;
					end
				end
				if (hit < 0)
					hit = wild;
			end
			CMD_COUNT: begin
				a.active_count = 6'(live_slots());
			end
			CMD_NTH: begin
				for (i = 0; i < mark; i++) begin
					if (slot_live[i]) begin
						if (hit < 0 && n == w.slot_index)
							hit = i;
						n++;
					end
				end
			end
			default: begin
				for (i = 0; i < SLOTS; i++)
					slot_live[i] = 1'b0;
				mark = 0;
			end
		endcase
		if (w.command != CMD_COUNT && w.command != CMD_CLEAR) begin
			if (hit < 0)
				a.status = 1'b1;
			else
				a.slot_found = 5'(hit);
		end
		return a;
	endfunction

	function automatic req_t word_of(cmd_t c, logic [2:0] kind, logic [63:0] key,
			logic any, logic [4:0] idx);
		req_t w;
		w.command = c;
		w.entry_kind = kind;
		w.match_key = key;
		w.any_leaf = any;
		w.slot_index = idx;
		return w;
	endfunction

	function automatic drill_row_t row(req_t w, bit typed, bit st, int slot, int cnt);
		drill_row_t d;
		d.word = w;
		d.typed = typed;
		d.answer.status = st;
		d.answer.slot_found = 5'(slot);
		d.answer.active_count = 6'(cnt);
		return d;
	endfunction

	// Random word shaped by the predicted table, so lookups and removes mostly land.
	function automatic req_t random_word();
		req_t w;
		int r;
		int live_n;
		w.command = CMD_COUNT;
		w.entry_kind = 3'($urandom_range(0, 7));
		w.match_key = {$urandom, $urandom};
		w.any_leaf = 1'($urandom_range(0, 1));
		w.slot_index = 5'($urandom_range(0, 31));
		r = $urandom_range(0, 99);
		live_n = live_slots();
		if ((mark == SLOTS && $urandom_range(0, 7) == 0) || $urandom_range(0, 399) == 0) begin
			w.command = CMD_CLEAR;
		end else if (r < 38) begin
			w.command = CMD_INSERT;
			case ($urandom_range(0, 9))
				0, 1, 2: w.entry_kind = KIND_BREAKPOINT;
				3, 4, 5: w.entry_kind = KIND_CPUID;
				6, 7: w.entry_kind = KIND_DESCRIPTOR;
				default: ;
			endcase
			case ($urandom_range(0, 3))
				0: w.match_key = 64'($urandom_range(0, 7));
				1: w.match_key = {$urandom, 32'($urandom_range(0, 7))};
				2: ;
				default: w.match_key = $urandom_range(0, 1) ? KEY_ONES : '0;
			endcase
			if ($urandom_range(0, 2) != 0)
				w.any_leaf = 1'b0;
		end else if (r < 55) begin
			w.command = CMD_REMOVE;
			if (mark > 0 && $urandom_range(0, 3) != 0)
				w.slot_index = 5'($urandom_range(0, mark - 1));
		end else if (r < 85) begin
			w.command = (r < 65) ? CMD_FIND_BP : (r < 75) ? CMD_FIND_CPU : CMD_FIND_DSC;
			if (mark > 0 && $urandom_range(0, 9) < 7)
				w.match_key = slot_key[$urandom_range(0, mark - 1)];
			else if ($urandom_range(0, 1) == 0)
				w.match_key = 64'($urandom_range(0, 7));
			if (w.command == CMD_FIND_CPU && $urandom_range(0, 1) == 0)
				w.match_key[63:32] = $urandom;
		end else if (r < 90) begin
			w.command = CMD_COUNT;
		end else begin
			w.command = CMD_NTH;
			if ($urandom_range(0, 3) != 0)
				w.slot_index = 5'($urandom_range(0, (live_n + 1 > 31) ? 31 : live_n + 1));
		end
		return w;
	endfunction

	task automatic send_word(input req_t w, input bit typed, input rsp_t answer);
		rsp_t got;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (req_stall !== 1'b0)
			@(posedge clk);
		got = table_apply(w);
		awaited_answers.push_back(typed ? answer : got);
	endtask

	task automatic report(input string field, input int want, input int seen);
		mismatches++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, seen);
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (rsp_valid && !rsp_stall) begin
			if (awaited_answers.size() == 0) begin
				mismatches++;
				$display("%0t: response word with nothing expected, status %0d slot %0d count %0d",
					$realtime, rsp.status, rsp.slot_found, rsp.active_count);
			end else begin
				want = awaited_answers.pop_front();
				if (rsp.status !== want.status)
					report("status", want.status, rsp.status);
				if (rsp.slot_found !== want.slot_found)
					report("slot_found", want.slot_found, rsp.slot_found);
				if (rsp.active_count !== want.active_count)
					report("active_count", want.active_count, rsp.active_count);
			end
		end
		rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		drill = '{
			row(word_of(CMD_COUNT, KIND_REGISTER, '0, 1'b0, 5'd0), 1, 0, 0, 0),
			row(word_of(CMD_FIND_BP, KIND_REGISTER, '0, 1'b0, 5'd0), 1, 1, 0, 0),
			row(word_of(CMD_FIND_CPU, KIND_REGISTER, KEY_ONES, 1'b1, 5'd31), 1, 1, 0, 0),
			row(word_of(CMD_REMOVE, KIND_REGISTER, '0, 1'b0, 5'd31), 1, 1, 0, 0),
			row(word_of(CMD_NTH, KIND_REGISTER, '0, 1'b0, 5'd0), 1, 1, 0, 0),
			row(word_of(CMD_INSERT, KIND_BREAKPOINT, KEY_ONES, 1'b0, 5'd0), 1, 0, 0, 0),
			row(word_of(CMD_INSERT, KIND_CPUID, '0, 1'b1, 5'd0), 0, 0, 0, 0),
			row(word_of(CMD_INSERT, KIND_CPUID, 64'hFFFF_FFFF_0000_0005, 1'b0, 5'd0), 0, 0, 0, 0),
			// Only the low half of the leaf takes part in a cpuid lookup.
			row(word_of(CMD_FIND_CPU, KIND_REGISTER, 64'h5, 1'b0, 5'd0), 0, 0, 0, 0),
			row(word_of(CMD_FIND_CPU, KIND_REGISTER, 64'h7, 1'b0, 5'd0), 0, 0, 0, 0),
			row(word_of(CMD_INSERT, KIND_DESCRIPTOR, '0, 1'b1, 5'd0), 0, 0, 0, 0),
			row(word_of(CMD_FIND_DSC, KIND_REGISTER, '0, 1'b0, 5'd0), 0, 0, 0, 0),
			row(word_of(CMD_INSERT, KIND_UNLISTED, KEY_ONES, 1'b1, 5'd31), 0, 0, 0, 0),
			row(word_of(CMD_FIND_BP, KIND_UNLISTED, KEY_ONES, 1'b0, 5'd0), 0, 0, 0, 0),
			row(word_of(CMD_INSERT, KIND_REGISTER, 64'h5, 1'b1, 5'd0), 0, 0, 0, 0),
			row(word_of(CMD_INSERT, KIND_CPUID, 64'h9, 1'b1, 5'd0), 0, 0, 0, 0),
			row(word_of(CMD_FIND_CPU, KIND_REGISTER, 64'h1234, 1'b0, 5'd0), 0, 0, 0, 0),
			row(word_of(CMD_REMOVE, KIND_REGISTER, '0, 1'b0, 5'd1), 0, 0, 0, 0),
			row(word_of(CMD_INSERT, KIND_MEM, '0, 1'b0, 5'd0), 0, 0, 0, 0),
			row(word_of(CMD_COUNT, KIND_REGISTER, '0, 1'b0, 5'd0), 0, 0, 0, 0),
			row(word_of(CMD_NTH, KIND_REGISTER, '0, 1'b0, 5'd6), 0, 0, 0, 0),
			row(word_of(CMD_NTH, KIND_REGISTER, KEY_ONES, 1'b1, 5'd31), 1, 1, 0, 0),
			row(word_of(CMD_CLEAR, KIND_UNLISTED, KEY_ONES, 1'b1, 5'd31), 1, 0, 0, 0),
			row(word_of(CMD_COUNT, KIND_REGISTER, '0, 1'b0, 5'd0), 1, 0, 0, 0),
			row(word_of(CMD_FIND_BP, KIND_REGISTER, KEY_ONES, 1'b0, 5'd0), 1, 1, 0, 0)
		};
		for (int i = 0; i < SLOTS; i++) begin
			slot_live[i] = 1'b0;
			slot_kind[i] = '0;
			slot_key[i] = '0;
			slot_wild[i] = 1'b0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		foreach (drill[k])
			send_word(drill[k].word, drill[k].typed, drill[k].answer);
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle_pct = 0; rsp_stall_pct = 0; end
				1: begin send_idle_pct = 71; rsp_stall_pct = 0; end
				2: begin send_idle_pct = 0; rsp_stall_pct = 71; end
				default: begin send_idle_pct = 14; rsp_stall_pct = 14; end
			endcase
			// Let the row drain completely before each phase starts.
			req_valid <= 1'b0;
			while (awaited_answers.size() != 0)
				@(posedge clk);
			for (int n = 0; n < PHASE_WORDS; n++)
				send_word(random_word(), 1'b0, '0);
		end
		req_valid <= 1'b0;
		while (awaited_answers.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);
		if (mismatches == 0 && awaited_answers.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
